FILE: sv/dqrev_pkg.sv
// Shared types and constants for the double-ended queue with reverse.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dqrev_pkg;

    // Ring geometry
    localparam int DEPTH = 1024;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = AW + 1;

    // Decoupling queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;

    localparam int VW = 8;

    typedef enum logic [2:0] {
        CMD_POP_BACK   = 3'd0,
        CMD_POP_FRONT  = 3'd1,
        CMD_REVERSE    = 3'd2,
        CMD_PUSH_BACK  = 3'd3,
        CMD_PUSH_FRONT = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // One memory operation with its precomputed result status
    typedef struct packed {
        logic            wr_en;
        logic            rd_en;
        logic [AW-1:0]   addr;
        logic [VW-1:0]   data;
        status_t         status;
    } dqrev_op_t;

endpackage

`default_nettype wire

FILE: sv/double_ended_queue_with_reverse.sv
// Top level of the byte deque with constant-time reverse.
// Instantiates dqrev_front, dqrev_queue and dqrev_back; uses dqrev_pkg.
//
//   channel   direction  tdata                 tuser
//   s_*       in         [7:0] value           [2:0] command
//   m_*       out        [7:0] popped_value    [1:0] status
//
// One command word per cycle while the queue has room; each word yields
// one result word, passing the queue stage and then the registered store
// read. The single-port store takes one access per word.
// Reset empties the deque and clears the reversed flag; store contents are
// left as they are. A stalled output backs up into the four-entry queue,
// and s_tready drops only when that queue is full.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_with_reverse
    import dqrev_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,   // [7:0] value
    input  wire logic [2:0]     s_tuser,   // [2:0] command
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          m_tdata,   // [7:0] popped_value
    output logic [1:0]          m_tuser    // [1:0] status
);

    logic      q_full;
    logic      front_valid;
    dqrev_op_t front_op;
    logic      q_valid;
    logic      q_ready;
    dqrev_op_t q_op;

    // Accept and classify commands
    dqrev_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .op_valid (front_valid),
        .op       (front_op)
    );

    // Decouple front from back
    dqrev_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_op     (front_op),
        .full      (q_full),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_op    (q_op)
    );

    // Execute store operations and drive results
    dqrev_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (q_valid),
        .op_ready (q_ready),
        .op       (q_op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef NO_ASSERTIONS
    // Result data is zero unless the word carries a popped element
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_POPPED)) |-> (m_tdata == '0))
        else $error("nonzero popped_value without pop status");

    // An empty queue never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> s_tready)
        else $error("input stalled while operation queue empty");

    // An operation taken by the back part shows up as a result word
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |=> m_tvalid)
        else $error("taken operation produced no result word");
`endif

endmodule

`default_nettype wire

FILE: sv/dqrev_front.sv
// Front part: accepts command words, keeps ring pointers and order flag,
// classifies each command into one memory operation. Depends on dqrev_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dqrev_front
    import dqrev_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [VW-1:0]   s_tdata,
    input  wire logic [2:0]      s_tuser,
    input  wire logic            q_full,
    output logic                 op_valid,
    output dqrev_op_t            op
);

    localparam logic [CW-1:0] DEPTH_C    = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);

    logic [AW-1:0] first_reg, first_next;
    logic [CW-1:0] count_reg, count_next;
    logic          rev_reg, rev_next;

    logic          accept;
    logic          empty;
    logic          full;
    logic [CW-1:0] high_sum;
    logic [CW-1:0] last_sum;
    logic [AW-1:0] high_free;
    logic [AW-1:0] high_last;
    logic [AW-1:0] first_dec;
    logic [AW-1:0] first_inc;
    cmd_t          cmd;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign op_valid = accept;
    assign cmd      = cmd_t'(s_tuser);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg >= DEPTH_C);

    // Ring addresses of the free slot above the high end and of the high end
    assign high_sum  = {1'b0, first_reg} + count_reg;
    assign last_sum  = {1'b0, first_reg} + count_reg - CW'(1);
    assign high_free = (high_sum >= DEPTH_C) ? AW'(high_sum - DEPTH_C) : AW'(high_sum);
    assign high_last = (last_sum >= DEPTH_C) ? AW'(last_sum - DEPTH_C) : AW'(last_sum);
    assign first_dec = (first_reg == '0) ? LAST_SLOT : first_reg - AW'(1);
    assign first_inc = (first_reg == LAST_SLOT) ? '0 : first_reg + AW'(1);

    // Classify the command and work out the next pointer state
    always_comb
    begin
        first_next = first_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        op.wr_en   = 1'b0;
        op.rd_en   = 1'b0;
        op.addr    = first_reg;
        op.data    = s_tdata;
        op.status  = ST_DONE;
        case (cmd)
            CMD_POP_BACK, CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    op.status = ST_EMPTY;
                end
                else
                begin
                    op.rd_en   = 1'b1;
                    op.status  = ST_POPPED;
                    count_next = count_reg - CW'(1);
                    // pop back takes the high end in normal order
                    if ((cmd == CMD_POP_BACK) != rev_reg)
                    begin
                        op.addr = high_last;
                    end
                    else
                    begin
                        op.addr    = first_reg;
                        first_next = first_inc;
                    end
                end
            end
            CMD_REVERSE:
            begin
                rev_next = !rev_reg;
            end
            CMD_PUSH_BACK, CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    op.status = ST_FULL;
                end
                else
                begin
                    op.wr_en   = 1'b1;
                    count_next = count_reg + CW'(1);
                    // push back adds at the high end in normal order
                    if ((cmd == CMD_PUSH_BACK) != rev_reg)
                    begin
                        op.addr = high_free;
                    end
                    else
                    begin
                        op.addr    = first_dec;
                        first_next = first_dec;
                    end
                end
            end
            default:
            begin
                op.status = ST_DONE;
            end
        endcase
    end

    // Advance pointer state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end
        else if (accept)
        begin
            first_reg <= first_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/dqrev_queue.sv
// Short operation queue between the front and back parts.
// Depends on dqrev_pkg for the operation type and depth.
`timescale 1ns / 1ps
`default_nettype none

module dqrev_queue
    import dqrev_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  dqrev_op_t      in_op,
    output logic           full,
    output logic           out_valid,
    input  wire logic      out_ready,
    output dqrev_op_t      out_op
);

    dqrev_op_t      slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] fill_reg;
    logic           push;
    logic           pop;

    assign full      = (fill_reg == QCW'(QDEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_op    = slot_reg[rd_ptr_reg];
    assign push      = in_valid && !full;
    assign pop       = out_ready && out_valid;

    // Store incoming operations
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_op;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + QCW'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - QCW'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/dqrev_back.sv
// Back part: carries out queued memory operations on the element store
// and holds the result word for the output side. Depends on dqrev_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dqrev_back
    import dqrev_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           op_valid,
    output logic                op_ready,
    input  dqrev_op_t           op,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [VW-1:0]       m_tdata,
    output logic [1:0]          m_tuser
);

    logic [VW-1:0] mem [DEPTH];
    logic [VW-1:0] rd_data_reg;
    logic          valid_reg;
    logic          popped_reg;
    status_t       status_reg;
    logic          take;

    assign op_ready = !valid_reg || m_tready;
    assign take     = op_valid && op_ready;
    assign m_tvalid = valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = popped_reg ? rd_data_reg : '0;

    // Element store: one write or one registered read per operation
    always_ff @(posedge clk)
    begin
        if (take && op.wr_en)
        begin
            mem[op.addr] <= op.data;
        end
        if (take && op.rd_en)
        begin
            rd_data_reg <= mem[op.addr];
        end
    end

    // Hold result payload until the next operation is taken
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg <= op.status;
            popped_reg <= op.rd_en;
        end
    end

    // Output word valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: sim/dqrev_result_checker.sv
// Result checker for the byte deque with reverse: watches both stream channels,
// predicts every result word and compares it with what the block returns.
// Depends on dqrev_pkg for the command and status codes and the ring depth.
`timescale 1ns / 1ps

module dqrev_result_checker
    import dqrev_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] value
    input  logic [2:0]  s_tuser,   // [2:0] command
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] popped_value
    input  logic [1:0]  m_tuser,   // [1:0] status
    output int          fail_count,
    output int          results_pending,
    output int          deque_level,
    output int          accepted_words
);

    typedef struct packed {
        status_t         status;
        logic [VW-1:0]   value;
    } deque_result_t;

    // Shadow copy of the ring and its pointers
    logic [VW-1:0]  ring_mem [DEPTH];
    int             low_slot;
    int             held;
    logic           flipped;

    // Newest expected word at the front, oldest at the back
    deque_result_t  expected_results [$];

    // Apply one command to the shadow deque and return the result word it yields
    function automatic deque_result_t apply_command(input logic [2:0] cmd,
                                                    input logic [VW-1:0] val);
        deque_result_t res;
        logic          at_high;
        res.status = ST_DONE;
        res.value  = '0;
        case (cmd)
            CMD_POP_BACK, CMD_POP_FRONT:
            begin
                if (held == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    // back is the high end unless the order is flipped
                    at_high = (cmd == CMD_POP_BACK) != flipped;
                    if (at_high)
                    begin
                        res.value = ring_mem[AW'((low_slot + held - 1) % DEPTH)];
                    end
                    else
                    begin
                        res.value = ring_mem[AW'(low_slot)];
                        low_slot  = (low_slot + 1) % DEPTH;
                    end
                    held       = held - 1;
                    res.status = ST_POPPED;
                end
            end
            CMD_REVERSE:
            begin
                flipped = ~flipped;
            end
            CMD_PUSH_BACK, CMD_PUSH_FRONT:
            begin
                if (held >= DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    at_high = (cmd == CMD_PUSH_BACK) != flipped;
                    if (at_high)
                    begin
                        ring_mem[AW'((low_slot + held) % DEPTH)] = val;
                    end
                    else
                    begin
                        low_slot                = (low_slot == 0) ? DEPTH - 1 : low_slot - 1;
                        ring_mem[AW'(low_slot)] = val;
                    end
                    held = held + 1;
                end
            end
            default:
            begin
                // unused codes leave the deque alone
            end
        endcase
        return res;
    endfunction

    // Predict on each accepted command word, compare on each accepted result word
    always @(posedge clk or negedge rst_n)
    begin : track_words
        deque_result_t want;
        if (!rst_n)
        begin
            low_slot = 0;
            held     = 0;
            flipped  = 1'b0;
            expected_results.delete();
            fail_count      <= 0;
            results_pending <= 0;
            deque_level     <= 0;
            accepted_words  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_front(apply_command(s_tuser, s_tdata));
                accepted_words <= accepted_words + 1;
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, status %0d value %0d",
                             $time, m_tuser, m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_back();
                    if (m_tuser !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                    else if (m_tdata !== want.value)
                    begin
                        $display("%0t: popped value mismatch, expected %0d actual %0d",
                                 $time, want.value, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            results_pending <= expected_results.size();
            deque_level     <= held;
        end
    end

endmodule

FILE: sim/testbench.sv
// Top of the deque test: clock, reset, command stimulus and the verdict.
// Instantiates double_ended_queue_with_reverse and dqrev_result_checker; uses dqrev_pkg.
`timescale 1ns / 1ps

module testbench;

    import dqrev_pkg::*;

    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_MID   = 3'd6;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          fail_count;
    int          results_pending;
    int          deque_level;
    int          accepted_words;

    double_ended_queue_with_reverse DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    dqrev_result_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .results_pending (results_pending),
        .deque_level     (deque_level),
        .accepted_words  (accepted_words)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Stall the result channel at random
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Offer one command word, idling first at random, and hold it until accepted
    task automatic send_word(input logic [2:0] cmd, input logic [7:0] val);
        int target;
        target = accepted_words + 1;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= val;
        do
            @(negedge clk);
        while (accepted_words != target);
    endtask

    // Random command: a push with the given odds, else a pop, reverse or unused code
    task automatic send_random(input int push_pct);
        logic [2:0] cmd;
        int         pick;
        if ($urandom_range(0, 99) < push_pct)
        begin
            cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        end
        else
        begin
            pick = $urandom_range(0, 19);
            if (pick < 8)
                cmd = CMD_POP_BACK;
            else if (pick < 16)
                cmd = CMD_POP_FRONT;
            else if (pick < 18)
                cmd = CMD_REVERSE;
            else
                cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
        end
        send_word(cmd, 8'($urandom_range(0, 255)));
    endtask

    // Hold off the sender until every result word has come back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (results_pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words: empty pops, reverse on empty and single element, extremes
        send_idle_pct = 30;
        recv_idle_pct = 59;
        send_word(CMD_POP_BACK, 8'hFF);
        send_word(CMD_POP_FRONT, 8'h00);
        send_word(CMD_REVERSE, 8'h00);
        send_word(CMD_REVERSE, 8'hFF);
        send_word(CMD_PUSH_BACK, 8'h00);
        send_word(CMD_PUSH_FRONT, 8'hFF);
        send_word(CMD_POP_BACK, 8'h00);
        send_word(CMD_POP_FRONT, 8'h00);
        send_word(CMD_PUSH_BACK, 8'hA5);
        send_word(CMD_REVERSE, 8'h00);
        send_word(CMD_POP_BACK, 8'h00);
        send_word(CMD_PUSH_FRONT, 8'h5A);
        send_word(CMD_PUSH_BACK, 8'h3C);
        send_word(CMD_REVERSE, 8'h00);
        send_word(CMD_POP_FRONT, 8'h00);
        send_word(CMD_POP_BACK, 8'h00);
        send_word(CMD_POP_FRONT, 8'h00);
        send_word(CMD_UNUSED_FIRST, 8'hFF);
        send_word(CMD_UNUSED_MID, 8'h81);
        send_word(CMD_UNUSED_LAST, 8'h7E);
        send_word(CMD_REVERSE, 8'h00);
        send_word(CMD_PUSH_FRONT, 8'hC3);
        send_word(CMD_POP_BACK, 8'h00);

        // Balanced random commands around an almost empty deque
        repeat (100) send_random(50);
        wait_results_drained();

        // Fill the ring to the top, then knock on it while full
        send_idle_pct = 59;
        recv_idle_pct = 30;
        while (deque_level < DEPTH)
            send_random(96);
        repeat (4) send_random(100);
        send_word(CMD_POP_FRONT, 8'($urandom_range(0, 255)));
        send_word(CMD_PUSH_BACK, 8'($urandom_range(0, 255)));
        send_word(CMD_PUSH_FRONT, 8'($urandom_range(0, 255)));
        send_word(CMD_REVERSE, 8'($urandom_range(0, 255)));
        send_word(CMD_PUSH_BACK, 8'($urandom_range(0, 255)));
        wait_results_drained();

        // Full rate on both sides, drifting back down
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (150) send_random(35);
        wait_results_drained();

        repeat (20) @(negedge clk);
        if (fail_count == 0 && results_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
